/* hdl/ocfar_pkg.sv */
package ocfar_pkg;

    // Default build sizes
    localparam int DEF_MAX_REF    = 16;
    localparam int DEF_MAX_GUARD  = 16;
    localparam int DEF_MAX_BINS   = 8192;
    localparam int DEF_POWER_BITS = 32;

    // Fixed field widths
    localparam int CFG_W   = 5;
    localparam int SCALE_W = 24;
    localparam int DET_W   = 14;
    localparam int BIN_W   = 13;
    localparam int THR_W   = 56;
    localparam int FRAC_W  = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register reset values
    localparam logic [CFG_W-1:0]   RST_TRAIN_LEN     = 5'd8;
    localparam logic [CFG_W-1:0]   RST_GUARD_LEN     = 5'd2;
    localparam logic [CFG_W-1:0]   RST_RANK_FROM_TOP = 5'd6;
    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR  = 24'd65536;
    localparam logic [DET_W-1:0]   RST_DET_LIMIT     = 14'd8192;

    typedef enum logic [2:0] {
        REG_TRAIN_LEN,
        REG_GUARD_LEN,
        REG_RANK_FROM_TOP,
        REG_SCALE_FACTOR,
        REG_DET_LIMIT
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_MULT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic mult;
        logic emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic have_cell;
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

/* hdl/ocfar_ram.sv */
module ocfar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ocfar_ctrl.sv */
module ocfar_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ocfar_pkg::status_t status,
    output ocfar_pkg::cmd_t    cmd
);
    import ocfar_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.have_cell)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_MULT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ocfar_dp.sv */
module ocfar_dp #(
    parameter int MAX_REF    = ocfar_pkg::DEF_MAX_REF,
    parameter int MAX_GUARD  = ocfar_pkg::DEF_MAX_GUARD,
    parameter int MAX_BINS   = ocfar_pkg::DEF_MAX_BINS,
    parameter int POWER_BITS = ocfar_pkg::DEF_POWER_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ocfar_pkg::cmd_t                 cmd,
    output ocfar_pkg::status_t              status,
    input  logic [POWER_BITS-1:0]           power,
    input  logic                            frame_last,
    input  logic [ocfar_pkg::CFG_W-1:0]     train_len,
    input  logic [ocfar_pkg::CFG_W-1:0]     guard_len,
    input  logic [ocfar_pkg::CFG_W-1:0]     rank_from_top,
    input  logic [ocfar_pkg::SCALE_W-1:0]   scale_factor,
    input  logic [ocfar_pkg::DET_W-1:0]     det_limit,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [ocfar_pkg::BIN_W-1:0]     cut_index,
    output logic                            detected,
    output logic                            threshold_valid,
    output logic [ocfar_pkg::THR_W-1:0]     threshold,
    output logic [POWER_BITS-1:0]           cell_power,
    output logic                            run_last,
    output logic                            frame_done
);
    import ocfar_pkg::*;

    localparam int DEPTH     = 2 * (MAX_REF + MAX_GUARD) + 1;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int IDX_W     = $clog2(MAX_BINS);
    localparam int MAX_TRAIN = 2 * MAX_REF;
    localparam int TRAIN_W   = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
    localparam int CNT_W     = $clog2(MAX_TRAIN + 1);
    localparam int SPAN_W    = $clog2(MAX_REF + MAX_GUARD + 2);
    localparam int CMP_W     = IDX_W + SPAN_W + 1;
    localparam int PROD_W    = POWER_BITS + SCALE_W;

    // Window settings, saturated to the build limits
    logic [SPAN_W-1:0] r_sat;
    logic [SPAN_W-1:0] g_sat;
    logic [SPAN_W-1:0] span;

    assign r_sat = (int'(train_len) > MAX_REF)   ? SPAN_W'(MAX_REF)   : SPAN_W'(train_len);
    assign g_sat = (int'(guard_len) > MAX_GUARD) ? SPAN_W'(MAX_GUARD) : SPAN_W'(guard_len);
    assign span  = r_sat + g_sat;

    logic [IDX_W-1:0]      bin_cnt_reg;
    logic [IDX_W-1:0]      newest_reg;
    logic                  last_reg;
    logic [IDX_W:0]        ce_reg;
    logic [SLOT_W-1:0]     wr_slot_reg;
    logic [SLOT_W-1:0]     cut_slot_reg;
    logic [DET_W-1:0]      det_cnt_reg;
    logic [SPAN_W-1:0]     d_reg;
    logic                  side_reg;
    logic                  rd_cut_reg;
    logic                  rd_train_reg;
    logic [POWER_BITS-1:0] cut_pw_reg;
    logic [POWER_BITS-1:0] sorted_reg [MAX_TRAIN];
    logic [POWER_BITS-1:0] sorted_next [MAX_TRAIN];
    logic [CNT_W-1:0]      cnt_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  thr_ok_reg;
    logic                  out_valid_reg;

    logic [POWER_BITS-1:0] rdata;
    logic [SLOT_W-1:0]     raddr;
    logic [SLOT_W:0]       left_slot;
    logic [SLOT_W:0]       right_sum;
    logic [SLOT_W:0]       right_slot;
    logic                  in_left;
    logic                  in_right;
    logic                  take;
    logic [MAX_TRAIN-1:0]  ge;
    logic [CMP_W-1:0]      ce_w;
    logic [CMP_W-1:0]      newest_w;
    logic [CMP_W-1:0]      d_w;
    logic [CMP_W-1:0]      span_w;
    logic                  more;
    logic [PROD_W-1:0]     thr_val;
    logic [PROD_W-1:0]     pw_scaled;
    logic                  det;
    logic [CFG_W-1:0]      rank_m1;

    assign ce_w     = CMP_W'(ce_reg);
    assign newest_w = CMP_W'(newest_reg);
    assign d_w      = CMP_W'(d_reg);
    assign span_w   = CMP_W'(span);

    assign status.have_cell = (ce_w <= newest_w) && (last_reg || (ce_w + span_w <= newest_w));
    assign status.scan_end  = (d_reg > span);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Training neighbours of the cell under test, slot arithmetic mod DEPTH
    assign in_left    = (ce_w >= d_w);
    assign in_right   = (ce_w + d_w <= newest_w);
    assign left_slot  = ({1'b0, cut_slot_reg} >= (SLOT_W+1)'(d_reg))
                        ? {1'b0, cut_slot_reg} - (SLOT_W+1)'(d_reg)
                        : {1'b0, cut_slot_reg} + (SLOT_W+1)'(DEPTH) - (SLOT_W+1)'(d_reg);
    assign right_sum  = {1'b0, cut_slot_reg} + (SLOT_W+1)'(d_reg);
    assign right_slot = (right_sum >= (SLOT_W+1)'(DEPTH))
                        ? right_sum - (SLOT_W+1)'(DEPTH) : right_sum;

    always_comb
    begin
        if (cmd.start)
        begin
            raddr = cut_slot_reg;
        end
        else if (side_reg)
        begin
            raddr = right_slot[SLOT_W-1:0];
        end
        else
        begin
            raddr = left_slot[SLOT_W-1:0];
        end
    end

    ocfar_ram #(
        .WIDTH (POWER_BITS),
        .DEPTH (DEPTH)
    ) u_win (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (wr_slot_reg),
        .wdata (power),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Insertion into the descending list, one training value a cycle
    assign take = rd_train_reg && (rdata != '0);

    always_comb
    begin
        for (int j = 0; j < MAX_TRAIN; j++)
        begin
            ge[j] = (CNT_W'(j) < cnt_reg) && (sorted_reg[j] >= rdata);
        end
        for (int j = 0; j < MAX_TRAIN; j++)
        begin
            if (ge[j])
            begin
                sorted_next[j] = sorted_reg[j];
            end
            else if (j == 0)
            begin
                sorted_next[j] = rdata;
            end
            else if (ge[j-1])
            begin
                sorted_next[j] = rdata;
            end
            else
            begin
                sorted_next[j] = sorted_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sorted_reg <= sorted_next;
        end
        if (rd_cut_reg)
        begin
            cut_pw_reg <= rdata;
        end
    end

    // Threshold and decision
    assign rank_m1   = rank_from_top - CFG_W'(1);
    assign thr_val   = thr_ok_reg ? prod_reg : '0;
    assign pw_scaled = PROD_W'({cut_pw_reg, {FRAC_W{1'b0}}});
    assign det       = thr_ok_reg && (prod_reg != '0) && (pw_scaled > prod_reg)
                       && (det_cnt_reg < det_limit);
    assign more      = (ce_w + CMP_W'(1) <= newest_w)
                       && (last_reg || (ce_w + CMP_W'(1) + span_w <= newest_w));

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(sorted_reg[TRAIN_W'(rank_m1)]) * PROD_W'(scale_factor);
        end
        if (cmd.emit)
        begin
            cut_index       <= BIN_W'(ce_reg);
            detected        <= det;
            threshold_valid <= thr_ok_reg;
            threshold       <= THR_W'(thr_val);
            cell_power      <= cut_pw_reg;
            run_last        <= !more;
            frame_done      <= last_reg && (ce_w == newest_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg   <= '0;
            newest_reg    <= '0;
            last_reg      <= 1'b0;
            ce_reg        <= '0;
            wr_slot_reg   <= '0;
            cut_slot_reg  <= '0;
            det_cnt_reg   <= '0;
            d_reg         <= '0;
            side_reg      <= 1'b0;
            rd_cut_reg    <= 1'b0;
            rd_train_reg  <= 1'b0;
            cnt_reg       <= '0;
            thr_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_cut_reg   <= cmd.start;
            rd_train_reg <= cmd.scan && (side_reg ? in_right : in_left);
            if (take)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.load)
            begin
                newest_reg  <= bin_cnt_reg;
                last_reg    <= frame_last || (int'(bin_cnt_reg) == MAX_BINS - 1);
                bin_cnt_reg <= bin_cnt_reg + IDX_W'(1);
                wr_slot_reg <= (int'(wr_slot_reg) == DEPTH - 1)
                               ? '0 : wr_slot_reg + SLOT_W'(1);
            end
            if (cmd.start)
            begin
                cnt_reg  <= '0;
                d_reg    <= g_sat + SPAN_W'(1);
                side_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                side_reg <= !side_reg;
                if (side_reg)
                begin
                    d_reg <= d_reg + SPAN_W'(1);
                end
            end
            if (cmd.mult)
            begin
                thr_ok_reg <= (rank_from_top != '0)
                              && (CMP_W'(rank_from_top) <= CMP_W'(cnt_reg));
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                ce_reg        <= ce_reg + (IDX_W+1)'(1);
                cut_slot_reg  <= (int'(cut_slot_reg) == DEPTH - 1)
                                 ? '0 : cut_slot_reg + SLOT_W'(1);
                if (det)
                begin
                    det_cnt_reg <= det_cnt_reg + DET_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish && last_reg)
            begin
                bin_cnt_reg  <= '0;
                wr_slot_reg  <= '0;
                ce_reg       <= '0;
                cut_slot_reg <= '0;
                det_cnt_reg  <= '0;
                last_reg     <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CMP_W'(MAX_TRAIN))
        else $error("training count beyond list size");

    a_cells_behind: assert property (@(posedge clk) disable iff (!rst_n)
        ce_w <= newest_w + CMP_W'(1))
        else $error("cell judged ahead of received bins");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled transfer");

endmodule

/* hdl/os_cfar_detector_unit.sv */
// Sequence: an input is accepted only in idle; each cell that it makes ready is then judged
// in turn through the evaluate, scan, multiply and emit states, and each result is registered.
// Throughput: one input at a time; the scan of the window RAM for training cells makes one
// read per cycle, and emit waits while the previous result is stalled. An input that judges
// no cell goes back to idle after evaluate. Reset: asynchronous, active low; clears the
// frame counters and loads the register defaults. The window RAM is not cleared.
module os_cfar_detector_unit #(
    parameter int MAX_REF    = ocfar_pkg::DEF_MAX_REF,
    parameter int MAX_GUARD  = ocfar_pkg::DEF_MAX_GUARD,
    parameter int MAX_BINS   = ocfar_pkg::DEF_MAX_BINS,
    parameter int POWER_BITS = ocfar_pkg::DEF_POWER_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input transfer
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [POWER_BITS-1:0]          power,
    input  logic                           frame_last,
    // result transfer
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ocfar_pkg::BIN_W-1:0]    cut_index,
    output logic                           detected,
    output logic                           threshold_valid,
    output logic [ocfar_pkg::THR_W-1:0]    threshold,
    output logic [POWER_BITS-1:0]          cell_power,
    output logic                           run_last,
    output logic                           frame_done,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ocfar_pkg::ADDR_W-1:0]   paddr,
    input  logic [ocfar_pkg::DATA_W-1:0]   pwdata,
    output logic [ocfar_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import ocfar_pkg::*;

    logic [CFG_W-1:0]   train_len_reg;
    logic [CFG_W-1:0]   guard_len_reg;
    logic [CFG_W-1:0]   rank_from_top_reg;
    logic [SCALE_W-1:0] scale_factor_reg;
    logic [DET_W-1:0]   det_limit_reg;
    reg_idx_t           reg_sel;
    logic               wr_en;
    cmd_t               cmd;
    status_t            status;

    // Registers sit on word addresses; the word index picks one
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_len_reg     <= RST_TRAIN_LEN;
            guard_len_reg     <= RST_GUARD_LEN;
            rank_from_top_reg <= RST_RANK_FROM_TOP;
            scale_factor_reg  <= RST_SCALE_FACTOR;
            det_limit_reg     <= RST_DET_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_TRAIN_LEN:     train_len_reg     <= pwdata[CFG_W-1:0];
                REG_GUARD_LEN:     guard_len_reg     <= pwdata[CFG_W-1:0];
                REG_RANK_FROM_TOP: rank_from_top_reg <= pwdata[CFG_W-1:0];
                REG_SCALE_FACTOR:  scale_factor_reg  <= pwdata[SCALE_W-1:0];
                REG_DET_LIMIT:     det_limit_reg     <= pwdata[DET_W-1:0];
                default:           ;   // drop writes to unmapped words
            endcase
        end
    end

    // Read back, zero-extended; unmapped words read as zero
    always_comb
    begin
        case (reg_sel)
            REG_TRAIN_LEN:     prdata = DATA_W'(train_len_reg);
            REG_GUARD_LEN:     prdata = DATA_W'(guard_len_reg);
            REG_RANK_FROM_TOP: prdata = DATA_W'(rank_from_top_reg);
            REG_SCALE_FACTOR:  prdata = DATA_W'(scale_factor_reg);
            REG_DET_LIMIT:     prdata = DATA_W'(det_limit_reg);
            default:           prdata = '0;
        endcase
    end

    // Sequencer: accept, then judge each ready cell in turn
    ocfar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Window store, ranked training list, threshold multiply, result register
    ocfar_dp #(
        .MAX_REF    (MAX_REF),
        .MAX_GUARD  (MAX_GUARD),
        .MAX_BINS   (MAX_BINS),
        .POWER_BITS (POWER_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .power           (power),
        .frame_last      (frame_last),
        .train_len       (train_len_reg),
        .guard_len       (guard_len_reg),
        .rank_from_top   (rank_from_top_reg),
        .scale_factor    (scale_factor_reg),
        .det_limit       (det_limit_reg),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .cut_index       (cut_index),
        .detected        (detected),
        .threshold_valid (threshold_valid),
        .threshold       (threshold),
        .cell_power      (cell_power),
        .run_last        (run_last),
        .frame_done      (frame_done)
    );

endmodule

/* verif/tb_os_cfar_detector_unit.sv */
`timescale 1ns / 1ps

module tb_os_cfar_detector_unit;
    import ocfar_pkg::*;

    localparam int WIN_DEPTH = 65;
    localparam int MAX_TRAIN = 32;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [BIN_W-1:0]  cut_index;
        logic              detected;
        logic              threshold_valid;
        logic [THR_W-1:0]  threshold;
        logic [31:0]       cell_power;
        logic              run_last;
        logic              frame_done;
    } cell_verdict_t;

    // One row of the directed table; has_exp marks rows whose single verdict is typed in
    typedef struct {
        logic [31:0]   power;
        logic          frame_last;
        bit            has_exp;
        cell_verdict_t exp;
    } bin_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] power = '0;
    logic frame_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BIN_W-1:0] cut_index;
    logic detected;
    logic threshold_valid;
    logic [THR_W-1:0] threshold;
    logic [31:0] cell_power;
    logic run_last;
    logic frame_done;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    os_cfar_detector_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .power(power), .frame_last(frame_last),
        .out_valid(out_valid), .out_stall(out_stall), .cut_index(cut_index),
        .detected(detected), .threshold_valid(threshold_valid), .threshold(threshold),
        .cell_power(cell_power), .run_last(run_last), .frame_done(frame_done),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // Shadow copy of the block's registers and frame state
    logic [4:0]  sh_ref, sh_guard, sh_rank;
    logic [23:0] sh_scale;
    logic [13:0] sh_max_det;
    logic [31:0] win_pow [WIN_DEPTH];
    bit          win_ok  [WIN_DEPTH];
    int unsigned bins_seen, next_cut, det_count;

    cell_verdict_t verdict_q[$];
    int  errors = 0;
    int  cycle = 0;
    bit  long_hold = 1'b0;

    function automatic logic [31:0] bin_power(int unsigned idx);
        int unsigned s;
        s = idx % WIN_DEPTH;
        return win_ok[s] ? win_pow[s] : 32'd0;
    endfunction

    function automatic cell_verdict_t judge_cut(int unsigned c, int unsigned newest,
                                                int unsigned g, int unsigned r);
        logic [31:0] train [MAX_TRAIN];
        logic [31:0] v, key;
        int unsigned cnt, i, j, d;
        cell_verdict_t res;
        logic [63:0] thr;
        bit ok;
        cnt = 0;
        thr = '0;
        ok = 1'b0;
        for (d = g + 1; d <= g + r; d++) begin
            if (c >= d) begin
                v = bin_power(c - d);
                if (v != 0 && cnt < MAX_TRAIN) begin train[cnt] = v; cnt++; end
            end
            if (c + d <= newest) begin
                v = bin_power(c + d);
                if (v != 0 && cnt < MAX_TRAIN) begin train[cnt] = v; cnt++; end
            end
        end
        // descending order, largest first
        for (i = 1; i < cnt; i++) begin
            key = train[i];
            j = i;
            while (j > 0 && train[j-1] < key) begin
                train[j] = train[j-1];
                j--;
            end
            train[j] = key;
        end
        if (sh_rank >= 1 && sh_rank <= cnt) begin
            ok = 1'b1;
            thr = 64'(train[sh_rank-1]) * 64'(sh_scale);
        end
        res = '0;
        res.cut_index = c[BIN_W-1:0];
        res.threshold_valid = ok;
        res.threshold = thr[THR_W-1:0];
        res.cell_power = bin_power(c);
        if (ok && thr != 0 && ({res.cell_power, 16'd0} > thr) && det_count < sh_max_det) begin
            res.detected = 1'b1;
            det_count++;
        end
        return res;
    endfunction

    // Advance the shadow state by one bin and queue its verdicts
    task automatic predict_bin(input logic [31:0] pw, input logic fl, output int n);
        int unsigned b, g, r;
        bit last;
        cell_verdict_t res;
        b = bins_seen;
        g = (sh_guard > 16) ? 16 : sh_guard;
        r = (sh_ref > 16) ? 16 : sh_ref;
        last = fl || (b + 1 >= 8192);
        n = 0;
        win_pow[b % WIN_DEPTH] = pw;
        win_ok[b % WIN_DEPTH] = 1'b1;
        bins_seen = b + 1;
        while (next_cut <= b && (last || next_cut + g + r <= b)) begin
            res = judge_cut(next_cut, b, g, r);
            if (last && next_cut == b) res.frame_done = 1'b1;
            verdict_q.push_back(res);
            next_cut++;
            n++;
        end
        if (n > 0) verdict_q[$].run_last = 1'b1;
        if (last) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_ok[k] = 1'b0;
                win_pow[k] = '0;
            end
            bins_seen = 0;
            next_cut = 0;
            det_count = 0;
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRAIN_LEN:      sh_ref = val[4:0];
            REG_GUARD_LEN:      sh_guard = val[4:0];
            REG_RANK_FROM_TOP:  sh_rank = val[4:0];
            REG_SCALE_FACTOR:   sh_scale = val[23:0];
            default:            sh_max_det = val[13:0];
        endcase
    endtask

    // Wait until every verdict is in, then let the block settle before touching registers
    task automatic drain;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Offer one bin and hold it until the transfer happens
    task automatic send_bin(input logic [31:0] pw, input logic fl);
        int n;
        in_valid   <= 1'b1;
        power      <= pw;
        frame_last <= fl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_bin(pw, fl, n);
    endtask

    // Sender bursts: after a random run of transfers, sometimes a random gap
    int burst_left = 0;
    task automatic pace;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic random_frame(input int unsigned len, input int unsigned zero_pct);
        logic [31:0] pw;
        for (int unsigned k = 0; k < len; k++) begin
            pace();
            case ($urandom_range(0, 9))
                0: pw = $urandom();
                1: pw = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: pw = $urandom_range(1, 4000);
            endcase
            if ($urandom_range(0, 99) < zero_pct) pw = '0;
            // the odd spike gives detections
            if ($urandom_range(0, 7) == 0) pw = $urandom_range(100000, 32'h7FFF_FFFF);
            send_bin(pw, (k == len - 1));
        end
    endtask

    // Receiver stall pattern of its own, plus one long hold-off
    always @(posedge clk) begin
        if (long_hold) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 3) == 0) && (cycle % 300 > 100);
    end

    // Compare each transfer with the oldest queued verdict
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t unexpected result: actual bin %0d", $time, cut_index);
                errors++;
            end else begin
                cell_verdict_t e;
                cell_verdict_t a;
                e = verdict_q.pop_front();
                a = '{cut_index, detected, threshold_valid, threshold, cell_power,
                      run_last, frame_done};
                if (a.cut_index != e.cut_index) begin
                    $display("%0t cut_index exp %0d act %0d", $time, e.cut_index, a.cut_index);
                    errors++;
                end
                if (a.detected != e.detected) begin
                    $display("%0t detected bin %0d exp %0b act %0b", $time, e.cut_index,
                             e.detected, a.detected);
                    errors++;
                end
                if (a.threshold_valid != e.threshold_valid) begin
                    $display("%0t threshold_valid bin %0d exp %0b act %0b", $time,
                             e.cut_index, e.threshold_valid, a.threshold_valid);
                    errors++;
                end
                if (a.threshold != e.threshold) begin
                    $display("%0t threshold bin %0d exp %h act %h", $time, e.cut_index,
                             e.threshold, a.threshold);
                    errors++;
                end
                if (a.cell_power != e.cell_power) begin
                    $display("%0t cell_power bin %0d exp %h act %h", $time, e.cut_index,
                             e.cell_power, a.cell_power);
                    errors++;
                end
                if (a.run_last != e.run_last) begin
                    $display("%0t run_last bin %0d exp %0b act %0b", $time, e.cut_index,
                             e.run_last, a.run_last);
                    errors++;
                end
                if (a.frame_done != e.frame_done) begin
                    $display("%0t frame_done bin %0d exp %0b act %0b", $time, e.cut_index,
                             e.frame_done, a.frame_done);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (cycle > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed table: plain single-bin frames (no training cells), then one longer frame
    bin_row_t dir_tab [] = '{
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{13'd0, 1'b0, 1'b0, 56'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}},
        '{32'd0,         1'b1, 1'b1, '{13'd0, 1'b0, 1'b0, 56'd0, 32'd0,         1'b1, 1'b1}},
        '{32'd5,  1'b0, 1'b0, '0}, '{32'd6,  1'b0, 1'b0, '0}, '{32'd0, 1'b0, 1'b0, '0},
        '{32'd7,  1'b0, 1'b0, '0}, '{32'd8,  1'b0, 1'b0, '0}, '{32'd9, 1'b0, 1'b0, '0},
        '{32'd900000, 1'b0, 1'b0, '0}, '{32'd4, 1'b0, 1'b0, '0}, '{32'd3, 1'b0, 1'b0, '0},
        '{32'd10, 1'b0, 1'b0, '0}, '{32'd11, 1'b0, 1'b0, '0}, '{32'd12, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0}, '{32'd1, 1'b0, 1'b0, '0},
        '{32'd2, 1'b0, 1'b0, '0}, '{32'd13, 1'b0, 1'b0, '0}, '{32'd14, 1'b1, 1'b0, '0}
    };

    initial begin
        sh_ref = RST_TRAIN_LEN;
        sh_guard = RST_GUARD_LEN;
        sh_rank = RST_RANK_FROM_TOP;
        sh_scale = RST_SCALE_FACTOR;
        sh_max_det = RST_DET_LIMIT;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ok[k] = 1'b0;
            win_pow[k] = '0;
        end
        bins_seen = 0;
        next_cut = 0;
        det_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings; typed-in rows are checked against the table
        foreach (dir_tab[i]) begin
            send_bin(dir_tab[i].power, dir_tab[i].frame_last);
            if (dir_tab[i].has_exp && verdict_q[$] != dir_tab[i].exp) begin
                $display("%0t table row %0d exp %h act %h", $time, i, dir_tab[i].exp,
                         verdict_q[$]);
                errors++;
            end
        end
        in_valid <= 1'b0;
        drain();

        // Extremes: widest window, top rank, largest scale, budget of one
        reg_write(REG_TRAIN_LEN, 32'd16);
        reg_write(REG_GUARD_LEN, 32'd16);
        reg_write(REG_RANK_FROM_TOP, 32'd1);
        reg_write(REG_SCALE_FACTOR, 32'hFF_FFFF);
        reg_write(REG_DET_LIMIT, 32'd1);
        random_frame(40, 10);
        in_valid <= 1'b0;
        drain();

        // Narrowest: one training cell per side, no guard, zero scale, rank too large at times
        reg_write(REG_TRAIN_LEN, 32'd1);
        reg_write(REG_GUARD_LEN, 32'd0);
        reg_write(REG_SCALE_FACTOR, 32'd0);
        reg_write(REG_DET_LIMIT, 32'd8192);
        random_frame(12, 20);
        in_valid <= 1'b0;
        drain();

        // Hold the receiver off for a long stretch so the input backs up
        reg_write(REG_SCALE_FACTOR, 32'd40000);
        reg_write(REG_RANK_FROM_TOP, 32'd2);
        long_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            random_frame(20, 5);
        join
        in_valid <= 1'b0;
        drain();

        // Random settings over several frames, mostly small windows
        repeat (3) begin
            reg_write(REG_TRAIN_LEN, ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16)
                                                                  : $urandom_range(1, 8));
            reg_write(REG_GUARD_LEN, $urandom_range(0, 16));
            reg_write(REG_RANK_FROM_TOP, $urandom_range(1, 16));
            reg_write(REG_SCALE_FACTOR, ($urandom_range(0, 1)) ? $urandom_range(0, 24'hFF_FFFF)
                                                               : $urandom_range(20000, 200000));
            reg_write(REG_DET_LIMIT, ($urandom_range(0, 1)) ? $urandom_range(1, 4)
                                                            : 8192);
            random_frame($urandom_range(8, 24), $urandom_range(0, 30));
            in_valid <= 1'b0;
            drain();
        end

        // Back to reset settings for a final frame
        reg_write(REG_TRAIN_LEN, RST_TRAIN_LEN);
        reg_write(REG_GUARD_LEN, RST_GUARD_LEN);
        reg_write(REG_RANK_FROM_TOP, RST_RANK_FROM_TOP);
        reg_write(REG_SCALE_FACTOR, RST_SCALE_FACTOR);
        reg_write(REG_DET_LIMIT, RST_DET_LIMIT);
        random_frame(20, 10);
        in_valid <= 1'b0;
        drain();

        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
